// ===== rtl/core/abrr_pkg.sv =====
// package for the burst ram responder: constants, item types, state codes
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package abrr_pkg;
    localparam int DATA_BYTES_DEF = 8;
    localparam int MEM_WORDS_DEF  = 4096;
    localparam int MAX_BEATS_DEF  = 64;
    localparam int REQ_DEPTH_DEF  = 8;
    localparam int BEAT_DEPTH_DEF = 64;
    localparam logic [3:0] PAGE_COUNT_RESET = 4'd8;

    localparam logic [1:0] MODE_PUSH_REQ  = 2'd0;
    localparam logic [1:0] MODE_PUSH_BEAT = 2'd1;
    localparam logic [1:0] MODE_POLL      = 2'd2;

    localparam logic [1:0] BURST_INCR = 2'd1;
    localparam logic [1:0] BURST_WRAP = 2'd2;

    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_WRESP = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_FULL     = 3'd1;
    localparam logic [2:0] ERR_SIZE     = 3'd2;
    localparam logic [2:0] ERR_WRAP_LEN = 3'd3;
    localparam logic [2:0] ERR_BURST    = 3'd4;
    localparam logic [2:0] ERR_RANGE    = 3'd5;
    localparam logic [2:0] ERR_LONG     = 3'd6;

    typedef struct packed {
        logic [1:0]  mode;
        logic        is_write;
        logic [31:0] start_addr;
        logic [7:0]  req_id;
        logic [7:0]  beat_count_minus_one;
        logic [2:0]  size_log2;
        logic [1:0]  burst_type;
        logic [63:0] write_data;
        logic [7:0]  write_strobe;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  resp_id;
        logic [63:0] read_data;
        logic [2:0]  error_code;
        logic        is_last;
    } out_item_t;

    typedef struct packed {
        logic        wr;
        logic [31:0] addr;
        logic [7:0]  id;
        logic [7:0]  len;
        logic [2:0]  size;
        logic [1:0]  burst;
    } req_t;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_HEAD, ST_CHECK, ST_SCAN, ST_DECIDE,
        ST_RD_ADDR, ST_RD_WAIT, ST_RD_OUT, ST_WR_READ, ST_WR_WAIT,
        ST_WR_WRITE, ST_EMIT, ST_OUT_WAIT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic clear_step;
        logic push_req;
        logic push_beat;
        logic load_head;
        logic start_walk;
        logic step_walk;
        logic check_step;
        logic mem_rd;
        logic mem_wr;
        logic beat_rd;
        logic pop_beat;
        logic pop_req;
        logic drop_beats;
        logic set_code;
        logic load_res;
        logic [2:0] code;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_done;
        logic req_full;
        logic beat_full;
        logic req_empty;
        logic too_long;
        logic beats_short;
        logic is_wr;
        logic pre_bad;
        logic [2:0] pre_code;
        logic range_bad;
        logic walk_last;
        logic [2:0] err_code;
    } stat_t;
endpackage
`default_nettype wire

// ===== rtl/core/abrr_ram.sv =====
// generic single port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module abrr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output      logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

// ===== rtl/core/abrr_datapath.sv =====
// queues, address walker, memory and result register of the responder
// depends on abrr_pkg and abrr_ram
`timescale 1ns / 1ps
`default_nettype none
module abrr_datapath #(
    parameter int DATA_BYTES = 8,
    parameter int MEM_WORDS  = 4096,
    parameter int MAX_BEATS  = 64,
    parameter int REQ_DEPTH  = 8,
    parameter int BEAT_DEPTH = 64
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire abrr_pkg::in_item_t in_item,
    input  wire logic [3:0]        page_count,
    input  wire abrr_pkg::cmd_t    cmd,
    output      abrr_pkg::stat_t   stat,
    output      abrr_pkg::out_item_t res
);
    import abrr_pkg::*;

    localparam int MW   = $clog2(MEM_WORDS);
    localparam int RQW  = (REQ_DEPTH > 1) ? $clog2(REQ_DEPTH) : 1;
    localparam int BQW  = $clog2(BEAT_DEPTH);
    localparam int DW   = 8 * DATA_BYTES;
    localparam int OFFW = (DATA_BYTES > 1) ? $clog2(DATA_BYTES) : 1;
    localparam logic [3:0] DB = 4'(DATA_BYTES);

    // request queue (small, one read address)
    req_t req_q [REQ_DEPTH];
    logic [RQW-1:0] rq_head_reg, rq_tail_reg;
    logic [RQW:0]   rq_cnt_reg;
    logic [BQW-1:0] bq_head_reg, bq_tail_reg;
    logic [BQW:0]   bq_cnt_reg;
    req_t r_reg;

    logic [MW-1:0] clr_reg;
    logic [32:0] lower_reg, upper_reg, addr_reg;
    logic [11:0] nb_reg;
    logic [8:0]  left_reg;
    logic [2:0]  code_reg;
    logic        bad_reg;
    logic [63:0] wbuf_reg;
    logic [7:0]  wstrb_reg;

    function automatic logic [RQW-1:0] rq_inc(input logic [RQW-1:0] p);
        rq_inc = (p == RQW'(REQ_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rq_head_reg <= '0;
            rq_tail_reg <= '0;
            rq_cnt_reg  <= '0;
            bq_head_reg <= '0;
            bq_tail_reg <= '0;
            bq_cnt_reg  <= '0;
            clr_reg     <= '0;
        end
        else
        begin
            if (cmd.clear_step)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cmd.push_req)
            begin
                rq_tail_reg <= rq_inc(rq_tail_reg);
            end
            if (cmd.pop_req)
            begin
                rq_head_reg <= rq_inc(rq_head_reg);
            end
            rq_cnt_reg <= rq_cnt_reg + (RQW+1)'(cmd.push_req) - (RQW+1)'(cmd.pop_req);
            if (cmd.push_beat)
            begin
                bq_tail_reg <= bq_tail_reg + 1'b1;
            end
            if (cmd.pop_beat)
            begin
                bq_head_reg <= bq_head_reg + 1'b1;
                bq_cnt_reg  <= bq_cnt_reg + (BQW+1)'(cmd.push_beat) - 1'b1;
            end
            else if (cmd.drop_beats)
            begin
                bq_head_reg <= bq_head_reg + BQW'({1'b0, r_reg.len} + 9'd1);
                bq_cnt_reg  <= bq_cnt_reg + (BQW+1)'(cmd.push_beat)
                               - (BQW+1)'({1'b0, r_reg.len} + 9'd1);
            end
            else
            begin
                bq_cnt_reg <= bq_cnt_reg + (BQW+1)'(cmd.push_beat);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push_req)
        begin
            req_q[rq_tail_reg] <= '{wr: in_item.is_write, addr: in_item.start_addr,
                id: in_item.req_id, len: in_item.beat_count_minus_one,
                size: in_item.size_log2, burst: in_item.burst_type};
        end
        if (cmd.load_head)
        begin
            r_reg <= req_q[rq_head_reg];
        end
    end

    // burst geometry
    logic [11:0] nb;
    logic [8:0]  beats;
    logic [19:0] span;
    logic [32:0] aligned, lower;
    logic        wrap_ok;
    always_comb
    begin
        nb      = 12'd1 << r_reg.size;
        beats   = {1'b0, r_reg.len} + 9'd1;
        span    = 20'(nb) * 20'(beats);
        aligned = {1'b0, r_reg.addr} & ~33'(nb - 12'd1);
        lower   = (r_reg.burst == BURST_WRAP) ? ({1'b0, r_reg.addr} & ~33'(span - 20'd1))
                                              : aligned;
        wrap_ok = (beats == 9'd2) || (beats == 9'd4) || (beats == 9'd8) || (beats == 9'd16);
    end

    logic [32:0] addr_next;
    logic [MW-1:0] widx;
    logic [32:0]   wq;
    always_comb
    begin
        addr_next = addr_reg + 33'(nb_reg);
        if (addr_next == upper_reg)
        begin
            addr_next = lower_reg;
        end
        wq   = addr_reg >> OFFW;
        if (DATA_BYTES == 1)
        begin
            wq = addr_reg;
        end
        widx = wq[MW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start_walk)
        begin
            addr_reg  <= aligned;
            lower_reg <= lower;
            upper_reg <= lower + 33'(span);
            nb_reg    <= nb;
            left_reg  <= beats;
            bad_reg   <= 1'b0;
        end
        else if (cmd.step_walk)
        begin
            addr_reg <= addr_next;
            left_reg <= left_reg - 1'b1;
        end
        if (cmd.check_step)
        begin
            if (addr_reg >= {17'd0, page_count, 12'd0} || wq >= 33'(MEM_WORDS))
            begin
                bad_reg <= 1'b1;
            end
        end
        if (cmd.set_code)
        begin
            code_reg <= cmd.code;
        end
    end

    // beat queues
    logic [63:0] bq_d;
    logic [7:0]  bq_s;
    abrr_ram #(.WIDTH(72), .DEPTH(BEAT_DEPTH)) u_beat_ram (
        .clk   (clk),
        .we    (cmd.push_beat),
        .addr  (cmd.push_beat ? bq_tail_reg : bq_head_reg),
        .wdata ({in_item.write_data, in_item.write_strobe}),
        .rdata ({bq_d, bq_s})
    );

    logic [DW-1:0] mem_rd;
    logic [DW-1:0] mem_wd;
    logic [DW-1:0] lanes;
    always_comb
    begin
        for (int j = 0; j < DATA_BYTES; j++)
        begin
            lanes[8*j +: 8] = {8{wstrb_reg[j]}};
        end
        mem_wd = cmd.clear_step ? '0 : ((mem_rd & ~lanes) | (wbuf_reg[DW-1:0] & lanes));
    end
    always_ff @(posedge clk)
    begin
        if (cmd.beat_rd)
        begin
            wbuf_reg  <= bq_d;
            wstrb_reg <= bq_s;
        end
    end
    abrr_ram #(.WIDTH(DW), .DEPTH(MEM_WORDS)) u_mem (
        .clk   (clk),
        .we    (cmd.mem_wr || cmd.clear_step),
        .addr  (cmd.clear_step ? clr_reg : widx),
        .wdata (mem_wd),
        .rdata (mem_rd)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load_res)
        begin
            res.kind       <= (cmd.code == ERR_NONE) ? (cmd.mem_rd ? KIND_READ : KIND_WRESP)
                                                     : KIND_ERROR;
            res.resp_id    <= (cmd.code == ERR_FULL && in_item.mode == MODE_PUSH_BEAT) ? 8'd0 :
                              (cmd.code == ERR_FULL) ? in_item.req_id : r_reg.id;
            res.read_data  <= cmd.mem_rd ? 64'(mem_rd) : 64'd0;
            res.error_code <= cmd.code;
            res.is_last    <= !cmd.mem_rd || left_reg == 9'd1;
        end
    end

    always_comb
    begin
        stat.clear_done  = &clr_reg;
        stat.req_full    = rq_cnt_reg >= (RQW+1)'(REQ_DEPTH);
        stat.beat_full   = bq_cnt_reg >= (BQW+1)'(BEAT_DEPTH);
        stat.req_empty   = rq_cnt_reg == '0;
        stat.too_long    = beats > 9'(MAX_BEATS);
        stat.beats_short = r_reg.wr && (10'(bq_cnt_reg) < 10'(beats));
        stat.is_wr       = r_reg.wr;
        stat.pre_bad     = 1'b1;
        stat.pre_code    = ERR_NONE;
        if (nb > 12'(DB))
        begin
            stat.pre_code = ERR_SIZE;
        end
        else if (r_reg.burst == BURST_WRAP && !wrap_ok)
        begin
            stat.pre_code = ERR_WRAP_LEN;
        end
        else if (r_reg.burst != BURST_INCR && r_reg.burst != BURST_WRAP)
        begin
            stat.pre_code = ERR_BURST;
        end
        else
        begin
            stat.pre_bad = 1'b0;
        end
        stat.range_bad = bad_reg;
        stat.walk_last = left_reg == 9'd1;
        stat.err_code  = code_reg;
    end
endmodule
`default_nettype wire

// ===== rtl/core/abrr_ctrl.sv =====
// controller state machine of the responder
// depends on abrr_pkg
`timescale 1ns / 1ps
`default_nettype none
module abrr_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output      logic               in_stall,
    input  wire logic [1:0]         in_mode,
    output      logic               out_valid,
    input  wire logic               out_stall,
    input  wire abrr_pkg::stat_t    stat,
    output      abrr_pkg::cmd_t     cmd,
    output      logic               cfg_ready
);
    import abrr_pkg::*;

    state_t state_reg, state_next;
    logic   ov_reg, ov_next;
    logic   back_reg, back_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            ov_reg    <= 1'b0;
            back_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            back_reg  <= back_next;
        end
    end

    logic free;
    always_comb
    begin
        free       = !ov_reg || !out_stall;
        state_next = state_reg;
        ov_next    = ov_reg && out_stall;
        back_next  = back_reg;
        cmd        = '0;
        cmd.code   = ERR_NONE;
        in_stall   = 1'b1;
        cfg_ready  = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                cfg_ready      = 1'b1;
                if (stat.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                cfg_ready = !ov_reg;
                in_stall  = !free;
                if (in_valid && free)
                begin
                    case (in_mode)
                        MODE_PUSH_REQ:
                        begin
                            if (stat.req_full)
                            begin
                                cmd.code     = ERR_FULL;
                                cmd.load_res = 1'b1;
                                ov_next      = 1'b1;
                            end
                            else
                            begin
                                cmd.push_req = 1'b1;
                            end
                        end
                        MODE_PUSH_BEAT:
                        begin
                            if (stat.beat_full)
                            begin
                                cmd.code     = ERR_FULL;
                                cmd.load_res = 1'b1;
                                ov_next      = 1'b1;
                            end
                            else
                            begin
                                cmd.push_beat = 1'b1;
                            end
                        end
                        MODE_POLL:
                        begin
                            if (!stat.req_empty)
                            begin
                                cmd.load_head = 1'b1;
                                state_next    = ST_HEAD;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_HEAD:
            begin
                cmd.start_walk = 1'b1;
                if (stat.too_long)
                begin
                    cmd.set_code = 1'b1;
                    state_next   = ST_EMIT;
                    back_next    = 1'b0;
                    cmd.code     = ERR_LONG;
                end
                else if (stat.beats_short)
                begin
                    state_next = ST_IDLE;
                end
                else if (stat.pre_bad)
                begin
                    cmd.set_code = 1'b1;
                    state_next   = ST_EMIT;
                    back_next    = 1'b1;
                    cmd.code     = stat.pre_code;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.check_step = 1'b1;
                cmd.step_walk  = 1'b1;
                if (stat.walk_last)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (stat.range_bad)
                begin
                    cmd.set_code = 1'b1;
                    cmd.code     = ERR_RANGE;
                    back_next    = 1'b1;
                    state_next   = ST_EMIT;
                end
                else
                begin
                    cmd.start_walk = 1'b1;
                    state_next     = stat.is_wr ? ST_WR_READ : ST_RD_ADDR;
                end
            end
            ST_RD_ADDR:
            begin
                state_next = ST_RD_WAIT;
            end
            ST_RD_WAIT:
            begin
                if (free)
                begin
                    cmd.mem_rd   = 1'b1;
                    cmd.load_res = 1'b1;
                    ov_next      = 1'b1;
                    if (stat.walk_last)
                    begin
                        cmd.pop_req = 1'b1;
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        cmd.step_walk = 1'b1;
                        state_next    = ST_RD_ADDR;
                    end
                end
            end
            ST_WR_READ:
            begin
                state_next = ST_WR_WAIT;
            end
            ST_WR_WAIT:
            begin
                cmd.beat_rd = 1'b1;
                state_next  = ST_WR_WRITE;
            end
            ST_WR_WRITE:
            begin
                cmd.mem_wr   = 1'b1;
                cmd.pop_beat = 1'b1;
                if (stat.walk_last)
                begin
                    state_next = ST_OUT_WAIT;
                end
                else
                begin
                    cmd.step_walk = 1'b1;
                    state_next    = ST_WR_READ;
                end
            end
            ST_OUT_WAIT:
            begin
                if (free)
                begin
                    cmd.load_res = 1'b1;
                    ov_next      = 1'b1;
                    cmd.pop_req  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (free)
                begin
                    cmd.code       = stat.err_code;
                    cmd.load_res   = 1'b1;
                    ov_next        = 1'b1;
                    cmd.pop_req    = 1'b1;
                    cmd.drop_beats = back_reg && stat.is_wr;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = ov_reg;
endmodule
`default_nettype wire

// ===== rtl/core/axi_burst_ram_responder_unit.sv =====
// Burst RAM responder: request and write beat queues in front of a word memory.
// Input items: mode 0 queues an address request, mode 1 queues a write beat,
// mode 2 polls the head request, mode 3 is ignored. A poll of a burst of N
// beats checks the beat addresses one after another, then reads or writes the
// beats one at a time, one memory port doing the work; a read burst gives N
// result items, a write burst one response, a rejected request one error item.
// Results leave through one output register; the input is held off only while
// the memory is cleared, a poll is being served or the output register is full
// and stalled.
// After reset the memory is zeroed, one word a cycle, and no item is taken
// until that ends; page_count may be written then.
// page_count is written through cfg_valid/cfg_ready while idle.
// A stalled result holds its fields until taken.
// depends on abrr_pkg, abrr_ctrl, abrr_datapath
`timescale 1ns / 1ps
`default_nettype none
module axi_burst_ram_responder_unit #(
    parameter int DATA_BYTES = abrr_pkg::DATA_BYTES_DEF,
    parameter int MEM_WORDS  = abrr_pkg::MEM_WORDS_DEF,
    parameter int MAX_BEATS  = abrr_pkg::MAX_BEATS_DEF,
    parameter int REQ_DEPTH  = abrr_pkg::REQ_DEPTH_DEF,
    parameter int BEAT_DEPTH = abrr_pkg::BEAT_DEPTH_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output      logic                in_stall,
    input  wire abrr_pkg::in_item_t  in_item,
    output      logic                out_valid,
    input  wire logic                out_stall,
    output      abrr_pkg::out_item_t out_item,
    input  wire logic                cfg_valid,
    output      logic                cfg_ready,
    input  wire logic [3:0]          cfg_data
);
    import abrr_pkg::*;

    cmd_t  cmd;
    stat_t stat;
    logic [3:0] page_count_reg;
    out_item_t res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_count_reg <= PAGE_COUNT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            page_count_reg <= cfg_data;
        end
    end

    abrr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_mode   (in_item.mode),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd),
        .cfg_ready (cfg_ready)
    );

    abrr_datapath #(
        .DATA_BYTES (DATA_BYTES),
        .MEM_WORDS  (MEM_WORDS),
        .MAX_BEATS  (MAX_BEATS),
        .REQ_DEPTH  (REQ_DEPTH),
        .BEAT_DEPTH (BEAT_DEPTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_item    (in_item),
        .page_count (page_count_reg),
        .cmd        (cmd),
        .stat       (stat),
        .res        (res)
    );

    assign out_item = res;
endmodule
`default_nettype wire

// ===== rtl/core/abrr_checker.sv =====
// port checker for the responder, bound to the top level
// depends on abrr_pkg
`timescale 1ns / 1ps
`default_nettype none
module abrr_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                out_valid,
    input wire logic                out_stall,
    input wire abrr_pkg::out_item_t out_item
);
    import abrr_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("stalled result changed");
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.kind == KIND_ERROR |-> out_item.is_last)
        else $error("error result not last");
    a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.kind != KIND_ERROR |-> out_item.error_code == ERR_NONE)
        else $error("code without error");
    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_item.kind == KIND_READ || out_item.kind == KIND_WRESP ||
                       out_item.kind == KIND_ERROR))
        else $error("bad kind");
endmodule

bind axi_burst_ram_responder_unit abrr_checker u_abrr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
);
`default_nettype wire
